// ===== hdl/cid_pkg.sv =====
// Shared types and constants for the compressed integer decoder.
// No dependencies; imported by every module in hdl/.
package cid_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned UsedW  = 3;
  localparam int unsigned LeftW  = 3;
  localparam int unsigned LaneW  = 2;

  // Lead byte forms
  localparam logic [ByteW-1:0] LeadLeMark  = 8'hF0;
  localparam logic [ByteW-1:0] LeadAllOnes = 8'hFE;
  localparam logic [ByteW-1:0] LeadMaxOnes = 8'hFF;

  // Continuation bytes due after each multi-byte lead
  localparam logic [LeftW-1:0] TwoByteLeft  = 3'd1;
  localparam logic [LeftW-1:0] FourByteLeft = 3'd3;
  localparam logic [LeftW-1:0] LeLeft       = 3'd4;

  localparam logic [ValueW-1:0] FillBase = 32'hFFFF_FF00;
  localparam logic [ValueW-1:0] IntMin   = 32'h8000_0000;

  // One classified byte, passed from the front end to the assembler
  typedef struct packed {
    logic             fill;   // base value is all ones above the low byte
    logic             err;    // invalid lead byte
    logic             start;  // clear the accumulator first
    logic             last;   // value completes with this byte
    logic [LaneW-1:0] lane;   // byte lane to OR the data into
    logic [UsedW-1:0] used;   // bytes consumed, valid with last
    logic [ByteW-1:0] data;   // masked byte contribution
  } cid_cmd_t;

  // Low-bit-sign mapping applied in signed mode
  function automatic logic [ValueW-1:0] map_value(input logic smode,
                                                  input logic [ValueW-1:0] code);
    logic [ValueW-1:0] v;
    v = code >> 1;
    if (!smode) begin
      return code;
    end else if (code == {ValueW{1'b1}}) begin
      return IntMin;
    end else if (code[0]) begin
      return ~v;
    end
    return v;
  endfunction

endpackage

// ===== hdl/cid_front.sv =====
// Front end: tracks the position within the current code and classifies bytes.
// Depends on cid_pkg.
module cid_front import cid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,      // byte accepted this cycle
  input  logic [ByteW-1:0] data_byte,
  output cid_cmd_t         cmd
);

  logic [LeftW-1:0] bytes_left, bytes_left_next;
  logic [UsedW-1:0] byte_count, byte_count_next;
  logic             le_form, le_form_next;
  logic [UsedW-1:0] count_inc;
  logic [LaneW-1:0] le_lane;
  logic [LaneW-1:0] be_lane;
  logic [LeftW-1:0] left_dec;

  assign count_inc = byte_count + 3'd1;
  assign left_dec  = bytes_left - 3'd1;
  assign le_lane   = LaneW'(byte_count - 3'd1);
  assign be_lane   = left_dec[LaneW-1:0];

  // Classify the byte and work out the next position
  always_comb begin
    cmd             = '0;
    bytes_left_next = bytes_left;
    byte_count_next = byte_count;
    le_form_next    = le_form;
    if (bytes_left == '0) begin
      cmd.start       = 1'b1;
      cmd.used        = 3'd1;
      byte_count_next = 3'd1;
      le_form_next    = 1'b0;
      priority if (!data_byte[7]) begin
        cmd.data = data_byte;
        cmd.last = 1'b1;
      end else if (data_byte[7:6] == 2'b10) begin
        cmd.data        = {2'b00, data_byte[5:0]};
        cmd.lane        = 2'd1;
        bytes_left_next = TwoByteLeft;
      end else if (data_byte[7:5] == 3'b110) begin
        cmd.data        = {3'b000, data_byte[4:0]};
        cmd.lane        = 2'd3;
        bytes_left_next = FourByteLeft;
      end else if (data_byte == LeadLeMark) begin
        le_form_next    = 1'b1;
        bytes_left_next = LeLeft;
      end else if (data_byte == LeadAllOnes || data_byte == LeadMaxOnes) begin
        cmd.fill = 1'b1;
        cmd.data = data_byte;
        cmd.last = 1'b1;
      end else begin
        cmd.err  = 1'b1;
        cmd.last = 1'b1;
      end
    end else begin
      cmd.data        = data_byte;
      cmd.lane        = le_form ? le_lane : be_lane;
      cmd.used        = count_inc;
      cmd.last        = (left_dec == '0);
      bytes_left_next = left_dec;
      byte_count_next = count_inc;
    end
  end

  // Advance position on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      byte_count <= '0;
      le_form    <= 1'b0;
    end else if (take) begin
      bytes_left <= bytes_left_next;
      byte_count <= byte_count_next;
      le_form    <= le_form_next;
    end
  end

endmodule

// ===== hdl/cid_queue.sv =====
// Two-entry command queue between the front end and the assembler.
// Depends on cid_pkg.
module cid_queue import cid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cid_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     nonempty,
  output cid_cmd_t head
);

  cid_cmd_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slot[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/cid_back.sv =====
// Back end: assembles values from classified bytes and holds the result register.
// Depends on cid_pkg.
module cid_back import cid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              signed_mode,
  input  logic              cmd_valid,
  input  cid_cmd_t          cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] value,
  output logic              format_error,
  output logic [UsedW-1:0]  bytes_used
);

  logic [ValueW-1:0] accumulator;
  logic [ValueW-1:0] base;
  logic [ValueW-1:0] placed;
  logic [ValueW-1:0] accumulator_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = cmd_valid && (!cmd.last || out_free);

  // Merge the byte into its lane
  always_comb begin
    priority if (cmd.fill) begin
      base = FillBase;
    end else if (cmd.start) begin
      base = '0;
    end else begin
      base = accumulator;
    end
    unique case (cmd.lane)
      2'd0:    placed = {24'd0, cmd.data};
      2'd1:    placed = {16'd0, cmd.data, 8'd0};
      2'd2:    placed = {8'd0, cmd.data, 16'd0};
      default: placed = {cmd.data, 24'd0};
    endcase
    accumulator_next = base | placed;
  end

  // Hold the partial value between bytes
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      accumulator <= cmd.last ? '0 : accumulator_next;
    end
  end

  // Result register: load on completion, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop && cmd.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.last) begin
      value        <= cmd.err ? '0 : map_value(signed_mode, accumulator_next);
      format_error <= cmd.err;
      bytes_used   <= cmd.used;
    end
  end

endmodule

// ===== hdl/compressed_int_decoder_core.sv =====
// Compressed integer decoder: one stream byte per cycle in, one result per code out.
// A code's final byte goes through the command queue, then the result register.
// Throughput: 1 byte per cycle unless m_tready stalls, via the 2-entry command queue.
// Reset (rst, synchronous): decoder idle awaiting a lead byte, queue and
// result register empty, signed_mode cleared.
// Depends on cid_pkg, cid_front, cid_queue, cid_back.
module compressed_int_decoder_core import cid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // signed_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // [31:0] value, [34:32] bytes_used, rest zero
  output logic        m_tuser        // [0] format_error
);

  logic              signed_mode;
  logic              take;
  logic              q_full;
  logic              q_nonempty;
  logic              q_pop;
  cid_cmd_t          front_cmd;
  cid_cmd_t          q_head;
  logic [ValueW-1:0] value;
  logic [UsedW-1:0]  bytes_used;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      signed_mode <= cfg_wdata;
    end
  end

  cid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .cmd       (front_cmd)
  );

  cid_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  cid_back u_back (
    .clk          (clk),
    .rst          (rst),
    .signed_mode  (signed_mode),
    .cmd_valid    (q_nonempty),
    .cmd          (q_head),
    .cmd_pop      (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .value        (value),
    .format_error (m_tuser),
    .bytes_used   (bytes_used)
  );

  assign m_tdata = {5'd0, bytes_used, value};

endmodule

// ===== tb/sv/compressed_int_decoder_core_chk.sv =====
// Checker for the compressed integer decoder: watches the byte stream, the
// result stream and the mode register, predicts each decoded value and
// compares it field by field. Depends on cid_pkg.
module compressed_int_decoder_core_chk
  import cid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [39:0]       m_tdata,
  input  logic              m_tuser,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              format_error;
    logic [UsedW-1:0]  bytes_used;
  } decoded_int_t;

  // Decoded values still to come out of the block, oldest first
  decoded_int_t decoded_q[$];

  // Shadow of the decoder state and the mode register
  logic [LeftW-1:0]  left_cnt;
  logic [ValueW-1:0] acc;
  logic              le_form;
  logic [UsedW-1:0]  used_cnt;
  logic              smode;

  // Low-bit-sign folding: all ones maps to the most negative value
  function automatic logic [ValueW-1:0] sign_fold(input logic mode,
                                                  input logic [ValueW-1:0] code);
    if (!mode) begin
      return code;
    end
    if (&code) begin
      return IntMin;
    end
    if (code[0]) begin
      return ~(code >> 1);
    end
    return code >> 1;
  endfunction

  task automatic queue_value(input logic [ValueW-1:0] val, input logic err,
                             input logic [UsedW-1:0] used);
    decoded_int_t r;
    r.value        = val;
    r.format_error = err;
    r.bytes_used   = used;
    decoded_q = {decoded_q, r};
  endtask

  // Advance the shadow decoder by one stream byte
  task automatic decode_byte(input logic [7:0] b);
    logic [LaneW-1:0] lane;
    if (left_cnt == '0) begin
      acc      = '0;
      le_form  = 1'b0;
      used_cnt = 3'd1;
      if (!b[7]) begin
        queue_value(sign_fold(smode, {24'h0, b}), 1'b0, 3'd1);
      end else if (b[7:6] == 2'b10) begin
        acc      = {18'h0, b[5:0], 8'h00};
        left_cnt = TwoByteLeft;
      end else if (b[7:5] == 3'b110) begin
        acc      = {3'b000, b[4:0], 24'h0};
        left_cnt = FourByteLeft;
      end else if (b == LeadLeMark) begin
        le_form  = 1'b1;
        left_cnt = LeLeft;
      end else if (b == LeadAllOnes) begin
        queue_value(sign_fold(smode, 32'hFFFF_FFFE), 1'b0, 3'd1);
      end else if (b == LeadMaxOnes) begin
        queue_value(sign_fold(smode, 32'hFFFF_FFFF), 1'b0, 3'd1);
      end else begin
        used_cnt = '0;
        queue_value('0, 1'b1, 3'd1);
      end
    end else begin
      lane     = le_form ? 2'(used_cnt - 3'd1) : 2'(left_cnt - 3'd1);
      acc      = acc | ({24'h0, b} << {lane, 3'b000});
      used_cnt = used_cnt + 3'd1;
      left_cnt = left_cnt - 3'd1;
      if (left_cnt == '0) begin
        queue_value(sign_fold(smode, acc), 1'b0, used_cnt);
        acc      = '0;
        le_form  = 1'b0;
        used_cnt = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] want);
    $display("%0t: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  // Check results first, then take in the mode write and the byte
  always @(posedge clk) begin
    decoded_int_t got;
    decoded_int_t want;
    if (rst) begin
      decoded_q.delete();
      left_cnt   = '0;
      acc        = '0;
      le_form    = 1'b0;
      used_cnt   = '0;
      smode      = 1'b0;
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.value        = m_tdata[31:0];
        got.bytes_used   = m_tdata[34:32];
        got.format_error = m_tuser;
        if (m_tdata[39:35] != '0) begin
          report_mismatch("tdata padding", {27'h0, m_tdata[39:35]}, '0);
        end
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing expected", got.value, '0);
        end else begin
          want = decoded_q.pop_front();
          if (got.value != want.value) begin
            report_mismatch("value", got.value, want.value);
          end
          if (got.format_error != want.format_error) begin
            report_mismatch("format_error", {31'h0, got.format_error},
                            {31'h0, want.format_error});
          end
          if (got.bytes_used != want.bytes_used) begin
            report_mismatch("bytes_used", {29'h0, got.bytes_used},
                            {29'h0, want.bytes_used});
          end
        end
      end
      if (cfg_we) begin
        smode = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata);
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ===== tb/sv/compressed_int_decoder_core_tb.sv =====
// Testbench top for the compressed integer decoder: clock, reset, byte
// stimulus, mode writes and result back-pressure; the verdict comes from
// the checker. Depends on cid_pkg, the decoder RTL and the checker.
module compressed_int_decoder_core_tb import cid_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int unsigned {
    FormShort, FormTwo, FormFour, FormLe, FormAllOnes, FormMaxOnes, FormBad, FormNoise
  } code_form_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent = 0;
  int unsigned calm_left  = 0;

  compressed_int_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  compressed_int_decoder_core_chk u_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Gap before the next byte: mostly none, some short, a few long,
  // with occasional calm stretches of back-to-back bytes
  function automatic int unsigned next_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(16, 64);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Encode one code of the given form around the payload
  task automatic send_code(input code_form_t form, input logic [31:0] payload);
    case (form)
      FormShort: begin
        send_byte({1'b0, payload[6:0]});
      end
      FormTwo: begin
        send_byte({2'b10, payload[13:8]});
        send_byte(payload[7:0]);
      end
      FormFour: begin
        send_byte({3'b110, payload[28:24]});
        send_byte(payload[23:16]);
        send_byte(payload[15:8]);
        send_byte(payload[7:0]);
      end
      FormLe: begin
        send_byte(LeadLeMark);
        send_byte(payload[7:0]);
        send_byte(payload[15:8]);
        send_byte(payload[23:16]);
        send_byte(payload[31:24]);
      end
      FormAllOnes: begin
        send_byte(LeadAllOnes);
      end
      FormMaxOnes: begin
        send_byte(LeadMaxOnes);
      end
      FormBad: begin
        if (payload[0]) begin
          send_byte({4'hE, 4'($urandom_range(0, 15))});
        end else begin
          send_byte(8'($urandom_range(8'hF1, 8'hFD)));
        end
      end
      default: begin
        send_byte(payload[7:0]);
      end
    endcase
  endtask

  // Mostly well-formed codes, the rest invalid leads and stray bytes
  function automatic code_form_t pick_form();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 22) return FormShort;
    if (roll < 40) return FormTwo;
    if (roll < 58) return FormFour;
    if (roll < 76) return FormLe;
    if (roll < 78) return FormAllOnes;
    if (roll < 80) return FormMaxOnes;
    if (roll < 88) return FormBad;
    return FormNoise;
  endfunction

  // Bias payloads towards all zeros and all ones
  function automatic logic [31:0] pick_payload();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Write the mode once the block has gone quiet
  task automatic set_mode(input logic m);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side back-pressure: ready runs broken by stalls
  initial begin
    int unsigned run;
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      run   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      m_tready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  initial begin
    int unsigned waited;
    int unsigned target;
    logic        m;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Field extremes and every form, unsigned
    set_mode(1'b0);
    send_code(FormShort, 32'h0000_0000);
    send_code(FormShort, 32'h0000_007F);
    send_code(FormTwo, 32'h0000_0000);
    send_code(FormTwo, 32'h0000_3FFF);
    send_code(FormFour, 32'h0000_0000);
    send_code(FormFour, 32'h1FFF_FFFF);
    send_code(FormLe, 32'h0403_0201);
    send_code(FormAllOnes, '0);
    send_code(FormMaxOnes, '0);
    send_byte(8'hE0);
    send_byte(8'hEF);
    send_byte(8'hF1);
    send_byte(8'hFD);

    // Signed folding, including all ones and invalid leads
    set_mode(1'b1);
    send_code(FormShort, 32'h0000_0000);
    send_code(FormShort, 32'h0000_0001);
    send_code(FormShort, 32'h0000_007F);
    send_code(FormAllOnes, '0);
    send_code(FormMaxOnes, '0);
    send_code(FormLe, 32'hFFFF_FFFF);
    send_byte(8'hE7);

    // Mode change while a value is half read: the new mode applies
    send_byte(LeadLeMark);
    send_byte(8'h11);
    set_mode(1'b0);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hAA);

    // Random phases, alternating the mode, the last one random
    for (int phase = 0; phase < 6; phase++) begin
      m = (phase == 5) ? 1'($urandom_range(0, 1)) : ~phase[0];
      set_mode(m);
      target = bytes_sent + 88;
      while (bytes_sent < target) begin
        send_code(pick_form(), pick_payload());
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
